// File: rtl/sba_pkg.sv
// Shared package for the slab bitmap allocator.
// Holds op and status codes, bitmap word geometry and the structs between blocks.
// No dependencies.
package sba_pkg;

   localparam int SLAB_NODES_DEF = 256;
   localparam int WORD_BITS      = 16;
   localparam logic [WORD_BITS-1:0] WORD_ONES = 16'hFFFF;
   localparam int BIT_SEL_MAX    = 15;

   localparam logic [1:0] OP_ALLOC1 = 2'd0;
   localparam logic [1:0] OP_ALLOCN = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_SIZE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_NOTALLC = 2'd2;
   localparam logic [1:0] ST_MISUSE  = 2'd3;

   typedef struct packed {
      logic set_used;
      logic clr_used;
      logic set_start;
      logic clr_start;
   } bm_cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
      logic used;
      logic start;
   } bm_rsp_type;

   typedef struct packed {
      logic [8:0] in_use;
      logic [8:0] run_length;
      logic [7:0] position;
      logic [1:0] status;
   } result_type;

endpackage

// File: rtl/slab_bitmap_allocator_top.sv
// Slab bitmap allocator: request channel in, one response beat per request out.
// Clears the bitmap memory word by word after reset, taking no request meanwhile.
// Requests on req_*: op, node_count, node_index; responses on rsp_*: status,
// position, run_length and the node count in use after the request.
// One request is worked at a time; req_tready is low while it runs.
// The sequencer steps one node per cycle through the bitmap word buffer while it
// holds the node's word; a step into another 16-node word first waits for that
// word to be read from memory into the buffer.
// An allocation marks its nodes one by one; a first-fit search, a free or a size
// query walks the bitmap node by node.
// The response sits in an output register: when the receiver stalls it holds,
// and the next request may be taken and worked meanwhile; the sequencer then
// waits with its result until the register is free.
// Synchronous active-high reset empties the slab and drops any pending beat.
// Depends on sba_pkg, sba_seq and sba_bitmap.
module slab_bitmap_allocator_top #(
   parameter int SLAB_NODES = sba_pkg::SLAB_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // op[1:0], node_count[10:2], node_index[18:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // status[1:0], position[9:2], run_length[18:10], in_use[27:19]
);
   import sba_pkg::*;

   localparam int NW = $clog2(SLAB_NODES) + 1;

   logic          probe;
   logic [NW-1:0] node;
   bm_cmd_type    cmd;
   bm_rsp_type    bm;
   result_type    res;
   logic          res_valid;
   logic          res_ready;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff, rsp_data_in;

   assign res_ready = !rsp_valid_ff || rsp_tready;

   sba_seq #(.SLAB_NODES(SLAB_NODES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tdata[1:0]),
      .in_count  (req_tdata[10:2]),
      .in_index  (req_tdata[18:11]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .probe     (probe),
      .node      (node),
      .cmd       (cmd),
      .bm        (bm)
   );

   sba_bitmap #(.SLAB_NODES(SLAB_NODES)) u_bitmap (
      .clock (clock),
      .reset (reset),
      .probe (probe),
      .node  (node),
      .cmd   (cmd),
      .rsp   (bm)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff.in_use, rsp_data_ff.run_length,
                        rsp_data_ff.position, rsp_data_ff.status};

endmodule

// File: rtl/sba_bitmap.sv
// Used and start bitmaps held as 16-node words in one memory, with a one-word buffer.
// Clears the memory after reset; depends on sba_pkg.
module sba_bitmap #(
   parameter int SLAB_NODES = sba_pkg::SLAB_NODES_DEF,
   localparam int NW = $clog2(SLAB_NODES) + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                probe,
   input  logic [NW-1:0]       node,
   input  sba_pkg::bm_cmd_type cmd,
   output sba_pkg::bm_rsp_type rsp
);
   import sba_pkg::*;

   localparam int WORDS = SLAB_NODES / WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [2*WORD_BITS-1:0] mem [WORDS];
   logic [2*WORD_BITS-1:0] rd_data_ff;

   logic                 clr_busy_ff, clr_busy_in;
   logic [WAW-1:0]       clr_addr_ff, clr_addr_in;
   logic [WORD_BITS-1:0] buf_used_ff, buf_used_in;
   logic [WORD_BITS-1:0] buf_start_ff, buf_start_in;
   logic [WAW-1:0]       buf_addr_ff, buf_addr_in;
   logic                 buf_valid_ff, buf_valid_in;
   logic                 buf_dirty_ff, buf_dirty_in;
   logic                 fill_ff, fill_in;
   logic [WAW-1:0]       fill_addr_ff, fill_addr_in;

   logic [WAW-1:0]         wa;
   logic [3:0]             bsel;
   logic                   hit;
   logic                   we, re;
   logic [WAW-1:0]         waddr, raddr;
   logic [2*WORD_BITS-1:0] wdata;

   assign wa   = WAW'(node >> 4);
   assign bsel = node[3:0];
   assign hit  = buf_valid_ff && !fill_ff && !clr_busy_ff && (buf_addr_ff == wa);

   assign rsp.busy  = clr_busy_ff;
   assign rsp.hit   = hit;
   assign rsp.used  = buf_used_ff[bsel];
   assign rsp.start = buf_start_ff[bsel];

   always_comb begin
      we           = 1'b0;
      re           = 1'b0;
      waddr        = buf_addr_ff;
      raddr        = wa;
      wdata        = {buf_start_ff, buf_used_ff};
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      buf_used_in  = buf_used_ff;
      buf_start_in = buf_start_ff;
      buf_addr_in  = buf_addr_ff;
      buf_valid_in = buf_valid_ff;
      buf_dirty_in = buf_dirty_ff;
      fill_in      = 1'b0;
      fill_addr_in = fill_addr_ff;
      if (clr_busy_ff) begin
         we          = 1'b1;
         waddr       = clr_addr_ff;
         wdata       = '0;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == WAW'(WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end else if (fill_ff) begin
         buf_used_in  = rd_data_ff[WORD_BITS-1:0] & WORD_ONES;
         buf_start_in = rd_data_ff[2*WORD_BITS-1:WORD_BITS];
         buf_addr_in  = fill_addr_ff;
         buf_valid_in = 1'b1;
         buf_dirty_in = 1'b0;
      end else if (probe && !hit) begin
         re           = 1'b1;
         we           = buf_valid_ff && buf_dirty_ff;
         fill_in      = 1'b1;
         fill_addr_in = wa;
      end else if (probe && hit) begin
         if (cmd.set_used) begin
            buf_used_in[bsel] = 1'b1;
         end
         if (cmd.clr_used) begin
            buf_used_in[bsel] = 1'b0;
         end
         if (cmd.set_start) begin
            buf_start_in[bsel] = 1'b1;
         end
         if (cmd.clr_start) begin
            buf_start_in[bsel] = 1'b0;
         end
         if (cmd.set_used || cmd.clr_used || cmd.set_start || cmd.clr_start) begin
            buf_dirty_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         buf_valid_ff <= 1'b0;
         buf_dirty_ff <= 1'b0;
         fill_ff      <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         buf_valid_ff <= buf_valid_in;
         buf_dirty_ff <= buf_dirty_in;
         fill_ff      <= fill_in;
      end
      buf_used_ff  <= buf_used_in;
      buf_start_ff <= buf_start_in;
      buf_addr_ff  <= buf_addr_in;
      fill_addr_ff <= fill_addr_in;
   end

endmodule

// File: rtl/sba_seq.sv
// Sequencer for allocate, free and size query, one bitmap node per step.
// Holds the marks and the node count; depends on sba_pkg and drives sba_bitmap.
module sba_seq #(
   parameter int SLAB_NODES = sba_pkg::SLAB_NODES_DEF,
   localparam int NW = $clog2(SLAB_NODES) + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_op,
   input  logic [8:0]          in_count,
   input  logic [7:0]          in_index,
   output logic                res_valid,
   input  logic                res_ready,
   output sba_pkg::result_type res,
   output logic                probe,
   output logic [NW-1:0]       node,
   output sba_pkg::bm_cmd_type cmd,
   input  sba_pkg::bm_rsp_type bm
);
   import sba_pkg::*;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DEC    = 4'd2;
   localparam logic [3:0] S_GRANT  = 4'd3;
   localparam logic [3:0] S_FFSCAN = 4'd4;
   localparam logic [3:0] S_SKIP   = 4'd5;
   localparam logic [3:0] S_RUN    = 4'd6;
   localparam logic [3:0] S_FIX    = 4'd7;
   localparam logic [3:0] S_CHK    = 4'd8;
   localparam logic [3:0] S_REND   = 4'd9;
   localparam logic [3:0] S_DOWN   = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   localparam logic [1:0] G_DONE   = 2'd0;
   localparam logic [1:0] G_FFSCAN = 2'd1;
   localparam logic [1:0] G_FIX    = 2'd2;
   localparam logic [1:0] G_UHMAX  = 2'd3;

   localparam logic [NW-1:0] NODES   = NW'(SLAB_NODES);
   localparam logic [NW:0]   NODES_W = (NW+1)'(SLAB_NODES);

   logic [3:0]    st_ff, st_in;
   logic [1:0]    op_ff, op_in;
   logic [8:0]    cnt_ff, cnt_in;
   logic [7:0]    idx_ff, idx_in;
   logic [NW-1:0] ptr_ff, ptr_in;
   logic [NW-1:0] base_ff, base_in;
   logic [NW-1:0] size_ff, size_in;
   logic [NW-1:0] ff_ff, ff_in;
   logic [NW-1:0] ul_ff, ul_in;
   logic [NW-1:0] uh_ff, uh_in;
   logic [NW-1:0] use_ff, use_in;
   logic [1:0]    gmode_ff, gmode_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    pos_ff, pos_in;
   logic [8:0]    len_ff, len_in;

   logic [NW:0]   base_end;
   logic [NW:0]   ptr_size;
   logic [NW:0]   uh_cnt;
   logic [NW-1:0] ptr_inc;
   logic [NW-1:0] uh_max;
   logic [NW-1:0] ff_min;
   logic [NW-1:0] ul_upd;
   logic          idx_oor;
   logic          cnt_big;
   logic          stop;

   assign base_end = {1'b0, base_ff} + {1'b0, size_ff};
   assign ptr_size = {1'b0, ptr_ff} + {1'b0, size_ff};
   assign uh_cnt   = {1'b0, uh_ff} + (NW+1)'(cnt_ff);
   assign ptr_inc  = ptr_ff + 1'b1;
   assign uh_max   = (base_end > {1'b0, uh_ff}) ? NW'(base_end) : uh_ff;
   assign ff_min   = (base_ff < ff_ff) ? base_ff : ff_ff;
   assign ul_upd   = (base_ff == ul_ff) ? ptr_ff : ul_ff;
   assign idx_oor  = 32'(idx_ff) >= SLAB_NODES;
   assign cnt_big  = 32'(cnt_ff) > SLAB_NODES;

   assign in_ready       = (st_ff == S_IDLE);
   assign res_valid      = (st_ff == S_DONE);
   assign res.status     = status_ff;
   assign res.position   = pos_ff;
   assign res.run_length = len_ff;
   assign res.in_use     = 9'(use_ff);
   assign node           = ptr_ff;

   always_comb begin
      st_in     = st_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      base_in   = base_ff;
      size_in   = size_ff;
      ff_in     = ff_ff;
      ul_in     = ul_ff;
      uh_in     = uh_ff;
      use_in    = use_ff;
      gmode_in  = gmode_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      probe     = 1'b0;
      cmd       = '0;
      stop      = 1'b0;
      case (st_ff)
         S_INIT: begin
            if (!bm.busy) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               op_in  = in_op;
               cnt_in = in_count;
               idx_in = in_index;
               st_in  = S_DEC;
            end
         end
         S_DEC: begin
            status_in = ST_OK;
            pos_in    = '0;
            len_in    = '0;
            case (op_ff)
               OP_ALLOC1: begin
                  if (uh_ff < NODES) begin
                     base_in  = uh_ff;
                     size_in  = NW'(1);
                     ptr_in   = uh_ff;
                     ul_in    = (ul_ff > uh_ff) ? uh_ff : ul_ff;
                     use_in   = use_ff + 1'b1;
                     pos_in   = 8'(uh_ff);
                     ff_in    = (ff_ff == uh_ff) ? uh_ff + 1'b1 : ff_ff;
                     uh_in    = uh_ff + 1'b1;
                     gmode_in = G_DONE;
                     st_in    = S_GRANT;
                  end else if (ff_ff < NODES) begin
                     base_in  = ff_ff;
                     size_in  = NW'(1);
                     ptr_in   = ff_ff;
                     ul_in    = (ul_ff > ff_ff) ? ff_ff : ul_ff;
                     use_in   = use_ff + 1'b1;
                     pos_in   = 8'(ff_ff);
                     gmode_in = G_FFSCAN;
                     st_in    = S_GRANT;
                  end else begin
                     status_in = ST_NOSPACE;
                     st_in     = S_DONE;
                  end
               end
               OP_ALLOCN: begin
                  if (cnt_ff == '0) begin
                     status_in = ST_MISUSE;
                     st_in     = S_DONE;
                  end else if (cnt_big) begin
                     status_in = ST_NOSPACE;
                     st_in     = S_DONE;
                  end else if (uh_cnt <= NODES_W) begin
                     base_in  = uh_ff;
                     size_in  = NW'(cnt_ff);
                     ptr_in   = uh_ff;
                     ul_in    = (ul_ff > uh_ff) ? uh_ff : ul_ff;
                     use_in   = use_ff + NW'(cnt_ff);
                     pos_in   = 8'(uh_ff);
                     ff_in    = (ff_ff == uh_ff) ? NW'(uh_cnt) : ff_ff;
                     uh_in    = NW'(uh_cnt);
                     gmode_in = G_DONE;
                     st_in    = S_GRANT;
                  end else begin
                     size_in = NW'(cnt_ff);
                     ptr_in  = ff_ff;
                     st_in   = S_SKIP;
                  end
               end
               default: begin
                  if (idx_oor) begin
                     status_in = ST_MISUSE;
                     st_in     = S_DONE;
                  end else begin
                     ptr_in  = NW'(idx_ff);
                     base_in = NW'(idx_ff);
                     st_in   = S_CHK;
                  end
               end
            endcase
         end
         S_GRANT: begin
            probe = 1'b1;
            if (bm.hit) begin
               cmd.set_used  = 1'b1;
               cmd.set_start = (ptr_ff == base_ff);
               ptr_in        = ptr_inc;
               if ({1'b0, ptr_inc} == base_end) begin
                  case (gmode_ff)
                     G_FFSCAN: st_in = S_FFSCAN;
                     G_FIX:    st_in = S_FIX;
                     G_UHMAX: begin
                        uh_in = uh_max;
                        st_in = S_DONE;
                     end
                     default:  st_in = S_DONE;
                  endcase
               end
            end
         end
         S_FFSCAN: begin
            if (ptr_ff >= NODES) begin
               ff_in = NODES;
               st_in = S_DONE;
            end else begin
               probe = 1'b1;
               if (bm.hit) begin
                  if (!bm.used) begin
                     ff_in = ptr_ff;
                     st_in = S_DONE;
                  end else begin
                     ptr_in = ptr_inc;
                  end
               end
            end
         end
         S_SKIP: begin
            if (ptr_size > NODES_W) begin
               status_in = ST_NOSPACE;
               st_in     = S_DONE;
            end else begin
               probe = 1'b1;
               if (bm.hit) begin
                  ptr_in = ptr_inc;
                  if (!bm.used) begin
                     base_in = ptr_ff;
                     st_in   = S_RUN;
                  end
               end
            end
         end
         S_RUN: begin
            if ({1'b0, ptr_ff} == base_end) begin
               ul_in    = (ul_ff > base_ff) ? base_ff : ul_ff;
               use_in   = use_ff + size_ff;
               pos_in   = 8'(base_ff);
               gmode_in = (base_ff == ff_ff) ? G_FIX : G_UHMAX;
               ptr_in   = base_ff;
               st_in    = S_GRANT;
            end else begin
               probe = 1'b1;
               if (bm.hit) begin
                  if (bm.used) begin
                     st_in = S_SKIP;
                  end else begin
                     ptr_in = ptr_inc;
                  end
               end
            end
         end
         S_FIX: begin
            if (ptr_ff >= uh_ff && ptr_ff >= NODES) begin
               ff_in = ptr_ff;
               uh_in = uh_max;
               st_in = S_DONE;
            end else begin
               probe = 1'b1;
               if (bm.hit) begin
                  if (ptr_ff >= uh_ff) begin
                     ff_in = bm.used ? NODES : ptr_ff;
                     uh_in = uh_max;
                     st_in = S_DONE;
                  end else if (!bm.used) begin
                     ff_in = ptr_ff;
                     uh_in = uh_max;
                     st_in = S_DONE;
                  end else begin
                     ptr_in = ptr_inc;
                  end
               end
            end
         end
         S_CHK: begin
            probe = 1'b1;
            if (bm.hit) begin
               if (op_ff == OP_FREE && !bm.used) begin
                  status_in = ST_NOTALLC;
                  st_in     = S_DONE;
               end else if (!bm.start) begin
                  status_in = ST_MISUSE;
                  st_in     = S_DONE;
               end else begin
                  if (op_ff == OP_FREE) begin
                     cmd.clr_used  = 1'b1;
                     cmd.clr_start = 1'b1;
                     use_in        = use_ff - 1'b1;
                  end
                  ptr_in = ptr_inc;
                  st_in  = S_REND;
               end
            end
         end
         S_REND: begin
            if (ptr_ff == uh_ff || ptr_ff >= NODES) begin
               stop = 1'b1;
            end else begin
               probe = 1'b1;
               if (bm.hit) begin
                  if (!bm.start && bm.used) begin
                     if (op_ff == OP_FREE) begin
                        cmd.clr_used = 1'b1;
                        use_in       = use_ff - 1'b1;
                     end
                     ptr_in = ptr_inc;
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            if (stop) begin
               st_in = S_DONE;
               if (op_ff == OP_SIZE) begin
                  len_in = 9'(ptr_ff - base_ff);
               end else begin
                  ff_in = ff_min;
                  ul_in = ul_upd;
                  if (ptr_ff == uh_ff) begin
                     if (ul_upd == uh_ff) begin
                        ff_in = '0;
                        ul_in = '0;
                        uh_in = '0;
                     end else if (ff_min == base_ff) begin
                        uh_in = base_ff;
                     end else begin
                        ptr_in = base_ff;
                        st_in  = S_DOWN;
                     end
                  end
               end
            end
         end
         S_DOWN: begin
            probe = 1'b1;
            if (bm.hit) begin
               if (bm.used) begin
                  uh_in = ptr_inc;
                  ff_in = (ff_ff > ptr_inc) ? ptr_inc : ff_ff;
                  st_in = S_DONE;
               end else if (ptr_ff == '0) begin
                  uh_in = '0;
                  ff_in = '0;
                  st_in = S_DONE;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_INIT;
         ff_ff  <= '0;
         ul_ff  <= '0;
         uh_ff  <= '0;
         use_ff <= '0;
      end else begin
         st_ff  <= st_in;
         ff_ff  <= ff_in;
         ul_ff  <= ul_in;
         uh_ff  <= uh_in;
         use_ff <= use_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      base_ff   <= base_in;
      size_ff   <= size_in;
      gmode_ff  <= gmode_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      len_ff    <= len_in;
   end

endmodule

// File: bench/tb_slab_bitmap_allocator_top.sv
// Testbench for the slab bitmap allocator: random and directed requests, with a
// predictor of the bitmaps and marks and a scoreboard of expected responses.
// Depends on sba_pkg and slab_bitmap_allocator_top.
class slab_scoreboard;
   sba_pkg::result_type pending_rsp[$];
   int errors = 0;

   function void note_request(sba_pkg::result_type r);
      pending_rsp.push_back(r);
   endfunction

   function void check_response(logic [31:0] d);
      sba_pkg::result_type e;
      if (pending_rsp.size() == 0) begin
         $error("unexpected response beat %h", d);
         errors++;
         return;
      end
      e = pending_rsp.pop_front();
      if (d[1:0] != e.status) begin
         $error("status exp %0d got %0d", e.status, d[1:0]); errors++;
      end
      if (d[9:2] != e.position) begin
         $error("position exp %0d got %0d", e.position, d[9:2]); errors++;
      end
      if (d[18:10] != e.run_length) begin
         $error("run_length exp %0d got %0d", e.run_length, d[18:10]); errors++;
      end
      if (d[27:19] != e.in_use) begin
         $error("in_use exp %0d got %0d", e.in_use, d[27:19]); errors++;
      end
   endfunction
endclass

module tb_slab_bitmap_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sba_pkg::*;

   localparam int NODES = 256;
   localparam int STALL_LIMIT = 20000;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [31:0] rsp_tdata;

   int send_idle = 29, recv_idle = 65;
   bit hold_off = 0;
   int idle_count = 0;
   slab_scoreboard sb = new();

   bit used_bm[NODES], start_bm[NODES];
   int unsigned free_mark, low_mark, high_mark, count_in_use;

   slab_bitmap_allocator_top u_top (.*);

   initial forever #5 clock = ~clock;

   function automatic bit node_used(int unsigned i);
      return i < NODES && used_bm[i];
   endfunction
   function automatic bit node_start(int unsigned i);
      return i < NODES && start_bm[i];
   endfunction
   function automatic int unsigned run_stop(int unsigned idx);
      int unsigned e = idx + 1;
      while (e != high_mark && e < NODES && !node_start(e) && node_used(e)) e++;
      return e;
   endfunction
   function automatic void mark_run(int unsigned idx, int unsigned n);
      start_bm[idx] = 1;
      for (int unsigned i = idx; i < idx + n && i < NODES; i++) used_bm[i] = 1;
      if (low_mark > idx) low_mark = idx;
      count_in_use += n;
   endfunction

   function automatic logic [1:0] take_single(output int unsigned pos);
      pos = 0;
      if (high_mark < NODES) begin
         pos = high_mark;
         mark_run(pos, 1);
         if (free_mark == pos) free_mark++;
         high_mark++;
         return ST_OK;
      end
      if (free_mark < NODES) begin
         pos = free_mark;
         mark_run(pos, 1);
         do free_mark++; while (free_mark != NODES && node_used(free_mark));
         return ST_OK;
      end
      return ST_NOSPACE;
   endfunction

   function automatic logic [1:0] take_run(int unsigned n, output int unsigned pos);
      int unsigned idx, last, i;
      pos = 0;
      if (n == 0) return ST_MISUSE;
      if (high_mark + n <= NODES) begin
         pos = high_mark;
         mark_run(pos, n);
         if (free_mark == pos) free_mark += n;
         high_mark += n;
         return ST_OK;
      end
      idx = free_mark;
      while (idx + n <= NODES) begin
         if (node_used(idx)) begin
            idx++;
            continue;
         end
         last = idx + 1;
         while (last != idx + n && !node_used(last)) last++;
         if (last == idx + n) begin
            mark_run(idx, n);
            if (idx == free_mark) begin
               for (i = free_mark + n; i < high_mark; i++)
                  if (!node_used(i)) break;
               free_mark = i;
               if (node_used(i)) free_mark = NODES;
            end
            if (high_mark < idx + n) high_mark = idx + n;
            pos = idx;
            return ST_OK;
         end
         idx = last;
         while (idx + n <= NODES && node_used(idx)) idx++;
      end
      return ST_NOSPACE;
   endfunction

   function automatic logic [1:0] release_run(int unsigned idx);
      int unsigned e, top, i;
      if (idx >= NODES) return ST_MISUSE;
      if (!node_used(idx)) return ST_NOTALLC;
      if (!node_start(idx)) return ST_MISUSE;
      top = high_mark;
      e = run_stop(idx);
      for (i = idx; i < e && i < NODES; i++) begin
         used_bm[i] = 0;
         count_in_use--;
      end
      start_bm[idx] = 0;
      if (idx < free_mark) free_mark = idx;
      if (idx == low_mark) low_mark = e;
      if (e == top) begin
         if (low_mark == top) begin
            free_mark = 0; low_mark = 0; high_mark = 0;
         end else if (free_mark == idx) begin
            high_mark = idx;
         end else begin
            i = idx + 1;
            while (i > 0 && !node_used(i - 1)) i--;
            high_mark = i;
            if (free_mark > high_mark) free_mark = high_mark;
         end
      end
      return ST_OK;
   endfunction

   function automatic result_type predict_result(logic [1:0] op, logic [8:0] cnt,
                                                 logic [7:0] idx);
      result_type r;
      int unsigned pos = 0, len = 0;
      case (op)
         OP_ALLOC1: r.status = take_single(pos);
         OP_ALLOCN: r.status = take_run(32'(cnt), pos);
         OP_FREE:   r.status = release_run(32'(idx));
         default: begin
            if (!node_start(32'(idx))) r.status = ST_MISUSE;
            else begin
               r.status = ST_OK;
               len = run_stop(32'(idx)) - 32'(idx);
            end
         end
      endcase
      if (r.status != ST_OK) pos = 0;
      r.position = pos[7:0];
      r.run_length = len[8:0];
      r.in_use = count_in_use[8:0];
      return r;
   endfunction

   task automatic send_request(logic [1:0] op, logic [8:0] cnt, logic [7:0] idx);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, idx, cnt, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(predict_result(op, cnt, idx));
   endtask

   task automatic random_request();
      int k = $urandom_range(99);
      logic [7:0] idx = 8'($urandom);
      if (k < 30) send_request(OP_ALLOC1, 9'($urandom), 8'd0);
      else if (k < 55) begin
         if ($urandom_range(9) == 0) send_request(OP_ALLOCN, 9'($urandom), 8'($urandom));
         else send_request(OP_ALLOCN, 9'($urandom_range(1, 12)), 8'($urandom));
      end else if (k < 85) begin
         // aim mostly at run starts
         if ($urandom_range(3) != 0) begin
            for (int t = 0; t < 64; t++) begin
               if (start_bm[idx]) break;
               idx = 8'($urandom);
            end
         end
         send_request(OP_FREE, 9'($urandom), idx);
      end else send_request(OP_SIZE, 9'($urandom), idx);
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed
      send_request(OP_SIZE, 9'd0, 8'd0);
      send_request(OP_FREE, 9'd0, 8'd0);
      send_request(OP_ALLOCN, 9'd0, 8'd0);
      send_request(OP_ALLOC1, 9'd0, 8'd0);
      send_request(OP_ALLOCN, 9'd5, 8'd0);
      send_request(OP_SIZE, 9'd0, 8'd1);
      send_request(OP_SIZE, 9'd0, 8'd3);
      send_request(OP_FREE, 9'd0, 8'd3);
      send_request(OP_ALLOCN, 9'h1FF, 8'hFF);
      send_request(OP_ALLOCN, 9'd256, 8'd0);
      send_request(OP_FREE, 9'd0, 8'd1);
      send_request(OP_ALLOCN, 9'd250, 8'd0);
      send_request(OP_SIZE, 9'd0, 8'd6);
      send_request(OP_ALLOC1, 9'd0, 8'd0);
      send_request(OP_ALLOC1, 9'd0, 8'd0);
      send_request(OP_FREE, 9'd0, 8'hFF);
      send_request(OP_FREE, 9'd0, 8'd0);
      send_request(OP_ALLOCN, 9'd3, 8'd0);
      send_request(OP_FREE, 9'd0, 8'd6);
      send_request(OP_SIZE, 9'd0, 8'hFF);
      send_request(OP_FREE, 9'd0, 8'd1);
      send_request(OP_ALLOCN, 9'd256, 8'd0);
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle = 65; recv_idle = 29; end
         if (ph == 2) begin send_idle = 0; recv_idle = 0; end
         for (int n = 0; n < 130; n++) random_request();
      end
      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         for (int n = 0; n < 10; n++) random_request();
      join
      req_tvalid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// File: files.f
rtl/sba_pkg.sv
rtl/sba_bitmap.sv
rtl/sba_seq.sv
rtl/slab_bitmap_allocator_top.sv
bench/tb_slab_bitmap_allocator_top.sv
